// ===== design/deq_pkg.sv =====
// Shared types and constants for the double-ended queue.
package deq_pkg;

  localparam int DEPTH = 1024;
  localparam int KEY_W = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_BACK   = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_PEEK_FRONT = 3'd4,
    REQ_PEEK_BACK  = 3'd5,
    REQ_CLEAR      = 3'd6,
    REQ_SIZE       = 3'd7
  } req_e_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_VALUE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e_t;

  // Command broadcast to every cell of a chain
  typedef enum logic [2:0] {
    OP_HOLD      = 3'd0,
    OP_SHIFT_IN  = 3'd1,
    OP_SHIFT_OUT = 3'd2,
    OP_APPEND    = 3'd3,
    OP_DROP_TAIL = 3'd4,
    OP_CLEAR     = 3'd5
  } cell_op_e_t;

  typedef struct packed {
    cell_op_e_t        op;
    logic [KEY_W-1:0]  key;
  } cell_ctrl_t;

  typedef struct packed {
    req_e_t                   req_type;
    logic signed [KEY_W-1:0]  push_key;
  } in_item_t;

  typedef struct packed {
    status_e_t                status;
    logic signed [KEY_W-1:0]  data_out;
    logic [CNT_W-1:0]         item_count;
  } out_item_t;

endpackage

// ===== design/double_ended_queue_top.sv =====
// Double-ended queue built from two mirrored cell chains, front-first and back-first.
// A result is valid in the cycle after its request transaction is accepted.
// Throughput: one request per cycle while the result side takes each result, since
// both queue ends sit at cell zero of a chain.
// Reset (rst_n low at a clock edge): count and cell occupancy clear, no result pending;
// stored keys are not cleared.
module double_ended_queue_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  deq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output deq_pkg::out_item_t out_data
);
  import deq_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  logic             accept;
  logic             full;
  logic             empty;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  out_item_t        out_data_r;
  out_item_t        result;
  cell_op_e_t       f_op;
  cell_op_e_t       b_op;
  cell_ctrl_t       f_ctrl;
  cell_ctrl_t       b_ctrl;
  logic [KEY_W-1:0] f_head;
  logic [KEY_W-1:0] b_head;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == DEPTH_CNT);
  assign empty    = (count_r == '0);

  always_comb begin
    f_op      = OP_HOLD;
    b_op      = OP_HOLD;
    count_nxt = count_r;
    result.status   = ST_OK;
    result.data_out = '0;
    case (in_data.req_type)
      REQ_PUSH_BACK: begin
        if (full) begin
          result.status = ST_FULL;
        end else begin
          b_op      = OP_SHIFT_IN;
          f_op      = OP_APPEND;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      REQ_PUSH_FRONT: begin
        if (full) begin
          result.status = ST_FULL;
        end else begin
          f_op      = OP_SHIFT_IN;
          b_op      = OP_APPEND;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      REQ_POP_BACK: begin
        if (empty) begin
          result.status = ST_EMPTY;
        end else begin
          result.status   = ST_VALUE;
          result.data_out = b_head;
          b_op      = OP_SHIFT_OUT;
          f_op      = OP_DROP_TAIL;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          result.status = ST_EMPTY;
        end else begin
          result.status   = ST_VALUE;
          result.data_out = f_head;
          f_op      = OP_SHIFT_OUT;
          b_op      = OP_DROP_TAIL;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      REQ_PEEK_FRONT: begin
        if (empty) begin
          result.status = ST_EMPTY;
        end else begin
          result.status   = ST_VALUE;
          result.data_out = f_head;
        end
      end
      REQ_PEEK_BACK: begin
        if (empty) begin
          result.status = ST_EMPTY;
        end else begin
          result.status   = ST_VALUE;
          result.data_out = b_head;
        end
      end
      REQ_CLEAR: begin
        f_op      = OP_CLEAR;
        b_op      = OP_CLEAR;
        count_nxt = '0;
      end
      REQ_SIZE: begin
      end
      default: begin
      end
    endcase
    result.item_count = count_nxt;
  end

  // Hold both chains unless a request transaction is taken this cycle
  assign f_ctrl.op  = accept ? f_op : OP_HOLD;
  assign f_ctrl.key = in_data.push_key;
  assign b_ctrl.op  = accept ? b_op : OP_HOLD;
  assign b_ctrl.key = in_data.push_key;

  deq_chain u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (f_ctrl),
    .head_key (f_head)
  );

  deq_chain u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (b_ctrl),
    .head_key (b_head)
  );

  assign out_valid_nxt = accept || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/deq_cell.sv =====
// One storage cell of a deque chain: a key and an occupancy bit.
module deq_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  deq_pkg::cell_ctrl_t       ctrl,
  input  logic [deq_pkg::KEY_W-1:0] left_key,
  input  logic                      left_occ,
  input  logic [deq_pkg::KEY_W-1:0] right_key,
  input  logic                      right_occ,
  output logic [deq_pkg::KEY_W-1:0] key_q,
  output logic                      occ_q
);
  import deq_pkg::*;

  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] key_nxt;
  logic             occ_r;
  logic             occ_nxt;

  always_comb begin
    key_nxt = key_r;
    occ_nxt = occ_r;
    case (ctrl.op)
      OP_HOLD: begin
      end
      OP_SHIFT_IN: begin
        key_nxt = left_key;
        occ_nxt = left_occ;
      end
      OP_SHIFT_OUT: begin
        key_nxt = right_key;
        occ_nxt = right_occ;
      end
      OP_APPEND: begin
        // the first empty cell takes the new key
        if (left_occ && !occ_r) begin
          key_nxt = ctrl.key;
        end
        occ_nxt = left_occ;
      end
      OP_DROP_TAIL: begin
        occ_nxt = right_occ;
      end
      OP_CLEAR: begin
        occ_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_q = key_r;
  assign occ_q = occ_r;

endmodule

// ===== design/deq_chain.sv =====
// Row of deque cells with the head entry exposed at cell zero.
module deq_chain (
  input  logic                      clk,
  input  logic                      rst_n,
  input  deq_pkg::cell_ctrl_t       ctrl,
  output logic [deq_pkg::KEY_W-1:0] head_key
);
  import deq_pkg::*;

  logic [KEY_W-1:0] key_w [DEPTH];
  logic [DEPTH-1:0] occ_w;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] lk;
    logic [KEY_W-1:0] rk;
    logic             lo;
    logic             ro;

    if (i == 0) begin : g_first
      assign lk = ctrl.key;
      assign lo = 1'b1;
    end else begin : g_left
      assign lk = key_w[i-1];
      assign lo = occ_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rk = '0;
      assign ro = 1'b0;
    end else begin : g_right
      assign rk = key_w[i+1];
      assign ro = occ_w[i+1];
    end

    deq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .left_key  (lk),
      .left_occ  (lo),
      .right_key (rk),
      .right_occ (ro),
      .key_q     (key_w[i]),
      .occ_q     (occ_w[i])
    );
  end

  assign head_key = key_w[0];

endmodule

// ===== design/deq_checker.sv =====
// Port-level checks for the double-ended queue, bound to the top level.
module deq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input deq_pkg::out_item_t out_data
);
  import deq_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result is stalled");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY |-> out_data.item_count == '0)
    else $error("empty error with keys stored");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |-> out_data.item_count == DEPTH_CNT)
    else $error("full error below capacity");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_VALUE |-> out_data.data_out == '0)
    else $error("data word set without a returned value");

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/double_ended_queue_top_tb.sv =====
// Self-checking testbench for double_ended_queue_top: ring-buffer deque predictor and scoreboard.
`timescale 1ns / 1ps

module double_ended_queue_top_tb;
  import deq_pkg::*;

  localparam int CYCLE_LIMIT = 20000;
  localparam int MAX_PRINTED = 50;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  double_ended_queue_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted deque contents
  logic [KEY_W-1:0] key_mem [DEPTH];
  int unsigned      front_slot = 0;
  int unsigned      back_slot = 0;
  int unsigned      key_count = 0;

  in_item_t  pending_reqs[$];
  out_item_t expected_results[$];
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        presented_count = 0;
  int        accepted_count = 0;
  int        err_count = 0;
  int        cycle_count = 0;

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTED) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic predict_request(input in_item_t req, output out_item_t res);
    int unsigned slot;
    res = '0;
    res.status = ST_OK;
    case (req.req_type)
      REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
        if (key_count >= DEPTH) begin
          res.status = ST_FULL;
        end else if (req.req_type == REQ_PUSH_BACK) begin
          key_mem[back_slot] = req.push_key;
          back_slot = (back_slot + 1) % DEPTH;
          key_count++;
        end else begin
          front_slot = (front_slot + DEPTH - 1) % DEPTH;
          key_mem[front_slot] = req.push_key;
          key_count++;
        end
      end
      REQ_POP_BACK, REQ_PEEK_BACK: begin
        if (key_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          slot = (back_slot + DEPTH - 1) % DEPTH;
          res.data_out = key_mem[slot];
          res.status = ST_VALUE;
          if (req.req_type == REQ_POP_BACK) begin
            back_slot = slot;
            key_count--;
          end
        end
      end
      REQ_POP_FRONT, REQ_PEEK_FRONT: begin
        if (key_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.data_out = key_mem[front_slot];
          res.status = ST_VALUE;
          if (req.req_type == REQ_POP_FRONT) begin
            front_slot = (front_slot + 1) % DEPTH;
            key_count--;
          end
        end
      end
      REQ_CLEAR: begin
        key_count = 0;
        front_slot = 0;
        back_slot = 0;
      end
      default: ;
    endcase
    res.item_count = CNT_W'(key_count);
  endtask

  // Driver: present requests and drive result-side backpressure at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      // hold an offered transaction until accepted
      if (!(in_valid && accepted_count != presented_count)) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_reqs[0];
          pending_reqs.delete(0);
          in_valid <= 1'b1;
          presented_count <= presented_count + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: check results, then predict for each accepted request
  always @(posedge clk) begin : monitor
    out_item_t want;
    out_item_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %p", got));
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
          if (got.data_out !== want.data_out)
            report_mismatch($sformatf("data_out %0d, expected %0d",
                                      got.data_out, want.data_out));
          if (got.item_count !== want.item_count)
            report_mismatch($sformatf("item_count %0d, expected %0d",
                                      got.item_count, want.item_count));
        end
      end
      if (in_valid && in_ready) begin
        predict_request(in_data, want);
        expected_results.insert(expected_results.size(), want);
        accepted_count <= accepted_count + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic in_item_t make_req(input req_e_t op, input logic [KEY_W-1:0] key);
    in_item_t r;
    r.req_type = op;
    r.push_key = key;
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    case ($urandom_range(15))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(input in_item_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic queue_op(input req_e_t op);
    add_req(make_req(op, random_key()));
  endtask

  task automatic queue_random(input int n);
    int push_pct;
    int r;
    push_pct = 50;
    for (int i = 0; i < n; i++) begin
      // shift the push rate every burst so the fill level wanders
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0: push_pct = 15;
          1: push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      if ($urandom_range(99) < push_pct) begin
        queue_op($urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK);
      end else begin
        r = $urandom_range(99);
        if (r < 3) queue_op(REQ_CLEAR);
        else if (r < 10) queue_op(REQ_SIZE);
        else begin
          case ($urandom_range(3))
            0: queue_op(REQ_POP_BACK);
            1: queue_op(REQ_POP_FRONT);
            2: queue_op(REQ_PEEK_FRONT);
            default: queue_op(REQ_PEEK_BACK);
          endcase
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || accepted_count != presented_count ||
           expected_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty errors, extreme keys at both ends, clear and size
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_op(REQ_SIZE);
    queue_op(REQ_PEEK_FRONT);
    queue_op(REQ_PEEK_BACK);
    queue_op(REQ_POP_BACK);
    queue_op(REQ_POP_FRONT);
    add_req(make_req(REQ_PUSH_BACK, 32'h7FFF_FFFF));
    add_req(make_req(REQ_PUSH_FRONT, 32'h8000_0000));
    add_req(make_req(REQ_PUSH_BACK, 32'hFFFF_FFFF));
    add_req(make_req(REQ_PUSH_FRONT, 32'h0000_0000));
    queue_op(REQ_PEEK_FRONT);
    queue_op(REQ_PEEK_BACK);
    queue_op(REQ_SIZE);
    queue_op(REQ_POP_FRONT);
    queue_op(REQ_POP_BACK);
    queue_op(REQ_POP_FRONT);
    queue_op(REQ_POP_BACK);
    queue_op(REQ_POP_BACK);
    add_req(make_req(REQ_PUSH_FRONT, 32'h5555_5555));
    add_req(make_req(REQ_PUSH_BACK, 32'hAAAA_AAAA));
    queue_op(REQ_CLEAR);
    queue_op(REQ_PEEK_FRONT);
    add_req(make_req(REQ_PUSH_FRONT, 32'h0000_0001));
    queue_op(REQ_POP_BACK);
    queue_op(REQ_SIZE);
    queue_random(180);
    wait_drained();

    send_idle_pct = 63;
    recv_stall_pct = 0;
    queue_random(180);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 63;
    queue_random(180);
    wait_drained();

    send_idle_pct = 35;
    recv_stall_pct = 35;
    queue_random(180);
    wait_drained();

    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
